[hw/rtl/chacha20_stream_xor_defines.svh]
// ----------------------------------------------------------------------------
// ChaCha20 stream XOR assertion macros
// Shared concurrent assertion helpers for the RTL of this block.
// ----------------------------------------------------------------------------
`ifndef CHACHA20_STREAM_XOR_DEFINES_SVH
`define CHACHA20_STREAM_XOR_DEFINES_SVH

// Clocked check, disabled while reset is asserted (active low).
`define CC20_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Clocked check that also holds during reset.
`define CC20_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/cc20_pkg.sv]
// ----------------------------------------------------------------------------
// ChaCha20 package
// Types and constants shared by the ChaCha20 stream XOR block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cc20_pkg;

  localparam int CfgIdxW = 3;
  localparam int CntW    = 4;
  localparam logic [CntW-1:0] MaxBytes = 4'd8;

  // Register map of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY0      = 3'd0,
    REG_KEY1      = 3'd1,
    REG_KEY2      = 3'd2,
    REG_KEY3      = 3'd3,
    REG_NONCE_LO  = 3'd4,
    REG_NONCE_HI  = 3'd5,
    REG_START_CTR = 3'd6
  } cfg_reg_e;

  localparam logic [3:0][31:0] Sigma = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };

  localparam int Rot1 = 16;
  localparam int Rot2 = 12;
  localparam int Rot3 = 8;
  localparam int Rot4 = 7;

  typedef logic [7:0][63:0] ks_blk_t;

  typedef struct packed {
    logic        start;
    logic [31:0] ctr;
  } core_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_sts_t;

endpackage

[hw/rtl/cc20_if.sv]
// ----------------------------------------------------------------------------
// ChaCha20 channel interfaces
// Valid/ready channels for message words, results and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cc20_in_if;
  logic                       valid;
  logic                       ready;
  logic [63:0]                data_bytes;
  logic [cc20_pkg::CntW-1:0]  byte_count;
  logic                       message_start;
  modport source (output valid, data_bytes, byte_count, message_start, input ready);
  modport sink   (input valid, data_bytes, byte_count, message_start, output ready);
endinterface

interface cc20_out_if;
  logic                       valid;
  logic                       ready;
  logic [63:0]                result_bytes;
  logic [cc20_pkg::CntW-1:0]  result_count;
  modport source (output valid, result_bytes, result_count, input ready);
  modport sink   (input valid, result_bytes, result_count, output ready);
endinterface

interface cc20_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cc20_pkg::CfgIdxW-1:0]  reg_index;
  logic [63:0]                   wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

[hw/rtl/cc20_qr.sv]
// ----------------------------------------------------------------------------
// ChaCha20 quarter-round lane
// One full quarter round on four 32-bit words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cc20_qr (
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  input  logic [31:0] d_i,
  output logic [31:0] a_o,
  output logic [31:0] b_o,
  output logic [31:0] c_o,
  output logic [31:0] d_o
);

  logic [31:0] a1, d1, c1, b1, a2, d2, c2, b2;
  logic [31:0] x1, x2, x3, x4;

  always_comb begin
    a1 = a_i + b_i;
    x1 = d_i ^ a1;
    d1 = {x1[31-cc20_pkg::Rot1:0], x1[31:32-cc20_pkg::Rot1]};
    c1 = c_i + d1;
    x2 = b_i ^ c1;
    b1 = {x2[31-cc20_pkg::Rot2:0], x2[31:32-cc20_pkg::Rot2]};
    a2 = a1 + b1;
    x3 = d1 ^ a2;
    d2 = {x3[31-cc20_pkg::Rot3:0], x3[31:32-cc20_pkg::Rot3]};
    c2 = c1 + d2;
    x4 = b1 ^ c2;
    b2 = {x4[31-cc20_pkg::Rot4:0], x4[31:32-cc20_pkg::Rot4]};
  end

  assign a_o = a2;
  assign b_o = b2;
  assign c_o = c2;
  assign d_o = d2;

endmodule

[hw/rtl/cc20_core.sv]
// ----------------------------------------------------------------------------
// ChaCha20 block core
// Four quarter-round lanes run one column or diagonal round per cycle;
// a final stage adds the input state back and packs the keystream block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "chacha20_stream_xor_defines.svh"

module cc20_core #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cc20_pkg::core_req_t req_i,
  input  logic [255:0]        key_i,
  input  logic [95:0]         nonce_i,
  output cc20_pkg::core_sts_t sts_o,
  output cc20_pkg::ks_blk_t   blk_o
);

  localparam int HalfRounds = 2 * DOUBLE_ROUNDS;
  localparam int RndW       = $clog2(HalfRounds);
  localparam logic [RndW-1:0] LastRnd = RndW'(HalfRounds - 1);

  logic [15:0][31:0] init_w, st_q, st_rnd, init_q;
  logic [3:0][31:0]  la, lb, lc, ld, ra, rb, rc, rd;
  logic              diag;
  logic [RndW-1:0]   rnd_q, rnd_d;
  logic              busy_q, busy_d, ff_q, ff_d, done_q, done_d;
  cc20_pkg::ks_blk_t blk_q;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      init_w[k] = cc20_pkg::Sigma[k];
    end
    for (int k = 0; k < 8; k++) begin
      init_w[4+k] = key_i[32*k +: 32];
    end
    init_w[12] = req_i.ctr;
    init_w[13] = nonce_i[31:0];
    init_w[14] = nonce_i[63:32];
    init_w[15] = nonce_i[95:64];
  end

  // even steps work on columns, odd steps on diagonals
  assign diag = rnd_q[0];

  for (genvar i = 0; i < 4; i++) begin : g_lane
    assign la[i] = st_q[i];
    assign lb[i] = diag ? st_q[4 + ((i + 1) % 4)]  : st_q[4 + i];
    assign lc[i] = diag ? st_q[8 + ((i + 2) % 4)]  : st_q[8 + i];
    assign ld[i] = diag ? st_q[12 + ((i + 3) % 4)] : st_q[12 + i];

    cc20_qr u_qr (
      .a_i(la[i]), .b_i(lb[i]), .c_i(lc[i]), .d_i(ld[i]),
      .a_o(ra[i]), .b_o(rb[i]), .c_o(rc[i]), .d_o(rd[i])
    );
  end

  // scatter lane results back to their row positions
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      st_rnd[j]      = ra[j];
      st_rnd[4 + j]  = diag ? rb[(j + 3) % 4] : rb[j];
      st_rnd[8 + j]  = diag ? rc[(j + 2) % 4] : rc[j];
      st_rnd[12 + j] = diag ? rd[(j + 1) % 4] : rd[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      st_q   <= init_w;
      init_q <= init_w;
    end else if (busy_q) begin
      st_q <= st_rnd;
    end
    if (ff_q) begin
      for (int w = 0; w < 8; w++) begin
        blk_q[w] <= {st_q[2*w+1] + init_q[2*w+1], st_q[2*w] + init_q[2*w]};
      end
    end
  end

  always_comb begin
    rnd_d  = rnd_q;
    busy_d = busy_q;
    ff_d   = 1'b0;
    done_d = done_q | ff_q;
    if (req_i.start) begin
      rnd_d  = '0;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      rnd_d = rnd_q + 1'b1;
      if (rnd_q == LastRnd) begin
        busy_d = 1'b0;
        ff_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q  <= '0;
      busy_q <= 1'b0;
      ff_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      rnd_q  <= rnd_d;
      busy_q <= busy_d;
      ff_q   <= ff_d;
      done_q <= done_d;
    end
  end

  assign sts_o.busy = busy_q | ff_q;
  assign sts_o.done = done_q;
  assign blk_o      = blk_q;

  `CC20_ASSERT(a_busy_done_excl, clk_i, rst_ni, !(sts_o.busy && done_q), "core busy and done")
  `CC20_ASSERT(a_ff_after_last, clk_i, rst_ni, ff_q |-> $past(busy_q) && $past(rnd_q) == LastRnd, "feed-forward without last round")
  `CC20_ASSERT(a_done_holds, clk_i, rst_ni, done_q && !req_i.start |=> done_q, "finished block dropped")

endmodule

[hw/rtl/chacha20_stream_xor.sv]
// ----------------------------------------------------------------------------
// ChaCha20 stream XOR
// Each word passes the input stage and the output register; a fresh block
// is computed one round per cycle on 4 lanes before the word can use it.
// A held block serves one word per cycle while the output is not stalled;
// the next block is computed while the current one is used.
// Reset clears control state; start counter resets to 1, keys to 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "chacha20_stream_xor_defines.svh"

module chacha20_stream_xor #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cc20_in_if.sink    in_i,
  cc20_out_if.source out_o,
  cc20_cfg_if.sink   cfg_i
);

  // configuration registers
  logic [3:0][63:0] key_q;
  logic [63:0]      nonce_lo_q;
  logic [31:0]      nonce_hi_q;
  logic [31:0]      start_ctr_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= '0;
      nonce_lo_q  <= '0;
      nonce_hi_q  <= '0;
      start_ctr_q <= 32'd1;
    end else if (cfg_i.valid) begin
      case (cc20_pkg::cfg_reg_e'(cfg_i.reg_index))
        cc20_pkg::REG_KEY0:      key_q[0]    <= cfg_i.wdata;
        cc20_pkg::REG_KEY1:      key_q[1]    <= cfg_i.wdata;
        cc20_pkg::REG_KEY2:      key_q[2]    <= cfg_i.wdata;
        cc20_pkg::REG_KEY3:      key_q[3]    <= cfg_i.wdata;
        cc20_pkg::REG_NONCE_LO:  nonce_lo_q  <= cfg_i.wdata;
        cc20_pkg::REG_NONCE_HI:  nonce_hi_q  <= cfg_i.wdata[31:0];
        cc20_pkg::REG_START_CTR: start_ctr_q <= cfg_i.wdata[31:0];
        default: ;
      endcase
    end
  end

  // input stage
  logic                      it_vld_q;
  logic [63:0]               it_data_q;
  logic [cc20_pkg::CntW-1:0] it_cnt_q;
  logic                      it_start_q;
  logic                      in_fire, fire;

  // keystream state
  logic [31:0]       ctr_q, ctr_d, core_ctr_q;
  logic [2:0]        pos_q, pos_d, pos_n;
  logic              rdy_q, rdy_d, core_ok_q;
  cc20_pkg::ks_blk_t ks_q, core_blk;

  // output register
  logic                      out_vld_q;
  logic [63:0]               out_data_q;
  logic [cc20_pkg::CntW-1:0] out_cnt_q;

  cc20_pkg::core_req_t req;
  cc20_pkg::core_sts_t sts;

  logic [31:0] eff_ctr;
  logic [2:0]  eff_pos;
  logic        eff_rdy, hit, pend, out_free, short_item;
  logic [63:0] ks_word, mask;

  assign in_fire     = in_i.valid && in_i.ready;
  assign in_i.ready  = !it_vld_q || fire;
  assign out_free    = !out_vld_q || out_o.ready;

  // a message start restarts position and counter before the lookup
  assign eff_ctr = it_start_q ? start_ctr_q : ctr_q;
  assign eff_pos = it_start_q ? 3'd0 : pos_q;
  assign eff_rdy = it_start_q ? 1'b0 : rdy_q;

  assign hit  = sts.done && core_ok_q && (core_ctr_q == eff_ctr);
  assign pend = sts.busy && core_ok_q && (core_ctr_q == eff_ctr);
  assign fire = it_vld_q && (eff_rdy || hit) && out_free;

  assign short_item = it_cnt_q < cc20_pkg::MaxBytes;
  assign pos_n      = eff_pos + 3'd1;

  always_comb begin
    ctr_d = ctr_q;
    pos_d = pos_q;
    rdy_d = rdy_q;
    if (fire) begin
      if (short_item) begin
        ctr_d = start_ctr_q;
        pos_d = 3'd0;
        rdy_d = 1'b0;
      end else begin
        ctr_d = eff_rdy ? eff_ctr : eff_ctr + 32'd1;
        pos_d = pos_n;
        rdy_d = (pos_n != 3'd0);
      end
    end
  end

  // launch a block for a waiting word, or prefetch the next one
  always_comb begin
    req.start = 1'b0;
    req.ctr   = eff_ctr;
    if (fire) begin
      req.ctr   = ctr_d;
      req.start = !(core_ok_q && (core_ctr_q == ctr_d) && (sts.busy || sts.done));
    end else if (it_vld_q && !eff_rdy && !hit && !pend) begin
      req.start = 1'b1;
    end
  end

  cc20_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .key_i   ({key_q[3], key_q[2], key_q[1], key_q[0]}),
    .nonce_i ({nonce_hi_q, nonce_lo_q}),
    .sts_o   (sts),
    .blk_o   (core_blk)
  );

  // a fresh block always serves position zero
  assign ks_word = eff_rdy ? ks_q[eff_pos] : core_blk[0];

  for (genvar b = 0; b < 8; b++) begin : g_mask
    assign mask[8*b +: 8] = {8{it_cnt_q > cc20_pkg::CntW'(b)}};
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      it_data_q  <= in_i.data_bytes;
      it_cnt_q   <= (in_i.byte_count > cc20_pkg::MaxBytes) ? cc20_pkg::MaxBytes
                                                           : in_i.byte_count;
      it_start_q <= in_i.message_start;
    end
    if (fire && !eff_rdy) begin
      ks_q <= core_blk;
    end
    if (fire) begin
      out_data_q <= (it_data_q ^ ks_word) & mask;
      out_cnt_q  <= it_cnt_q;
    end
    if (req.start) begin
      core_ctr_q <= req.ctr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      it_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      ctr_q     <= '0;
      pos_q     <= '0;
      rdy_q     <= 1'b0;
      core_ok_q <= 1'b0;
    end else begin
      if (in_fire) begin
        it_vld_q <= 1'b1;
      end else if (fire) begin
        it_vld_q <= 1'b0;
      end
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      ctr_q <= ctr_d;
      pos_q <= pos_d;
      rdy_q <= rdy_d;
      // drop any block made with the old key or nonce
      if (cfg_i.valid) begin
        core_ok_q <= 1'b0;
      end else if (req.start) begin
        core_ok_q <= 1'b1;
      end
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.result_bytes = out_data_q;
  assign out_o.result_count = out_cnt_q;

  `CC20_ASSERT(a_pos_zero_when_empty, clk_i, rst_ni, !rdy_q |-> pos_q == 3'd0, "position set without block")
  `CC20_ASSERT(a_stage_empty_ready, clk_i, rst_ni, !it_vld_q |-> in_i.ready, "empty stage refuses word")
  `CC20_ASSERT(a_fresh_block_hit, clk_i, rst_ni, fire && !eff_rdy |-> sts.done && core_ok_q, "stale block used")
  `CC20_ASSERT(a_count_bound, clk_i, rst_ni, out_vld_q |-> out_cnt_q <= cc20_pkg::MaxBytes, "result count above eight")

endmodule
